// ===== rtl/core/pnu_pkg.sv =====
`default_nettype none

package pnu_pkg;

  localparam int unsigned PAYLOAD_W = 61;
  localparam int unsigned HDR_CNT_W = 3;

  localparam logic [1:0] ADDR_STRIP = 2'd0;

  localparam logic [1:0] CLS_EMPTY = 2'd0;
  localparam logic [1:0] CLS_PLAIN = 2'd1;
  localparam logic [1:0] CLS_ZERO  = 2'd2;
  localparam logic [1:0] CLS_NONE  = 2'd3;

  localparam logic [3:0] NIB_MAX_PREFIX = 4'h5;
  localparam logic [3:0] NIB_ZERO_LOW   = 4'h4;
  localparam logic [3:0] NIB_PLAIN_LOW  = 4'h2;

  typedef struct packed {
    logic [3:0] nibble;
    logic       nibble_valid;
    logic       last;
    logic [1:0] prefix_class;
    logic       error;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } pair_t;

endpackage

`default_nettype wire

// ===== rtl/core/pnu_in_if.sv =====
`default_nettype none

interface pnu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pnu_out_if.sv =====
`default_nettype none

interface pnu_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] nibble;
  logic       nibble_valid;
  logic       last;
  logic [1:0] prefix_class;
  logic       error;

  modport source (output valid, output nibble, output nibble_valid, output last,
                  output prefix_class, output error, input ready);
  modport sink (input valid, input nibble, input nibble_valid, input last,
                input prefix_class, input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/prefixed_nibble_unpacker_unit.sv =====
// path: an accepted byte waits in the input register, is parsed once the result buffer can take
//   its results and is shown from that buffer; one byte per cycle when it gives one result or
//   none and the receiver takes each; a two-nibble byte holds the next until both are taken
// reset: synchronous, active high; clears the parser to await a header, empties the
//   result buffer and sets strip_prefix to 1
`default_nettype none

module prefixed_nibble_unpacker_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  pnu_in_if.sink           byte_stream,
  pnu_out_if.source        nibble_stream,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic           strip_prefix;
  logic           load_ok;
  logic           fire;
  pnu_pkg::pair_t pair;

  pnu_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .strip_prefix (strip_prefix)
  );

  pnu_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .byte_stream  (byte_stream),
    .strip_prefix (strip_prefix),
    .load_ok      (load_ok),
    .fire         (fire),
    .pair         (pair)
  );

  pnu_serializer u_ser (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .pair          (pair),
    .load_ok       (load_ok),
    .nibble_stream (nibble_stream)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pnu_cfg_regs.sv =====
`default_nettype none

module pnu_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             strip_prefix
);

  logic wr_en;

  assign wr_en  = psel & penable & pwrite & (paddr == pnu_pkg::ADDR_STRIP);
  assign pready = 1'b1;
  assign prdata = {31'd0, strip_prefix};

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_prefix <= 1'b1;
    end else if (wr_en) begin
      strip_prefix <= pwdata[0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pnu_parser.sv =====
`default_nettype none

module pnu_parser (
  input  wire logic   clk,
  input  wire logic   rst,
  pnu_in_if.sink      byte_stream,
  input  wire logic   strip_prefix,
  input  wire logic   load_ok,
  output logic        fire,
  output pnu_pkg::pair_t pair
);

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_EXT = 2'd1;
  localparam logic [1:0] PH_PAY = 2'd2;

  // input register
  logic       iv;
  logic [7:0] ib;
  logic       ie;

  logic [1:0]                        phase, phase_next;
  logic [pnu_pkg::HDR_CNT_W-1:0]     hbl, hbl_next;
  logic [pnu_pkg::PAYLOAD_W-1:0]     pl, pl_next;
  logic                              first, first_next;
  logic [1:0]                        cls, cls_next;

  logic [pnu_pkg::PAYLOAD_W-1:0]     pl_shift;
  logic [pnu_pkg::PAYLOAD_W-1:0]     pl_dec;
  logic [pnu_pkg::HDR_CNT_W-1:0]     hbl_dec;
  logic [3:0]                        hi;
  logic [3:0]                        lo;
  logic                              fin;
  logic [1:0]                        drop;
  logic [1:0]                        cls_use;
  logic                              done;

  pnu_pkg::result_t marker;
  pnu_pkg::result_t err_res;

  assign fire              = iv & load_ok;
  assign byte_stream.ready = ~iv | fire;

  assign hi       = ib[7:4];
  assign lo       = ib[3:0];
  assign pl_shift = {pl[pnu_pkg::PAYLOAD_W-9:0], ib};
  assign pl_dec   = pl - {{(pnu_pkg::PAYLOAD_W-1){1'b0}}, 1'b1};
  assign hbl_dec  = hbl - {{(pnu_pkg::HDR_CNT_W-1){1'b0}}, 1'b1};
  assign fin      = (pl == {{(pnu_pkg::PAYLOAD_W-1){1'b0}}, 1'b1});

  assign marker  = '{nibble: 4'd0, nibble_valid: 1'b0, last: 1'b1,
                     prefix_class: pnu_pkg::CLS_NONE, error: 1'b0};
  assign err_res = '{nibble: 4'd0, nibble_valid: 1'b0, last: 1'b1,
                     prefix_class: pnu_pkg::CLS_NONE, error: 1'b1};

  always_comb begin
    phase_next = phase;
    hbl_next   = hbl;
    pl_next    = pl;
    first_next = first;
    cls_next   = cls;
    pair       = '0;
    done       = 1'b0;
    drop       = 2'd0;
    cls_use    = cls;
    unique case (phase)
      PH_EXT: begin
        pl_next  = pl_shift;
        hbl_next = hbl_dec;
        if (hbl_dec == '0) begin
          first_next = 1'b1;
          cls_next   = pnu_pkg::CLS_NONE;
          if (pl_shift == '0) begin
            phase_next = PH_HDR;
            pair.cnt   = 2'd1;
            pair.r0    = marker;
            done       = 1'b1;
          end else begin
            phase_next = PH_PAY;
          end
        end
        if (!done && ie) begin
          phase_next = PH_HDR;
          hbl_next   = '0;
          pl_next    = '0;
          first_next = 1'b1;
          cls_next   = pnu_pkg::CLS_NONE;
          pair.cnt   = 2'd1;
          pair.r0    = err_res;
        end
      end
      PH_PAY: begin
        if (first) begin
          first_next = 1'b0;
          if (strip_prefix && hi <= pnu_pkg::NIB_MAX_PREFIX) begin
            drop = hi[0] ? 2'd1 : 2'd2;
            if (hi >= pnu_pkg::NIB_ZERO_LOW) begin
              cls_use = pnu_pkg::CLS_ZERO;
            end else if (hi >= pnu_pkg::NIB_PLAIN_LOW) begin
              cls_use = pnu_pkg::CLS_PLAIN;
            end else begin
              cls_use = pnu_pkg::CLS_EMPTY;
            end
          end else begin
            cls_use = pnu_pkg::CLS_NONE;
          end
          cls_next = cls_use;
        end
        pl_next = pl_dec;
        if (ie && !fin) begin
          phase_next = PH_HDR;
          pair.cnt   = 2'd1;
          pair.r0    = err_res;
        end else begin
          if (fin) begin
            phase_next = PH_HDR;
          end
          unique case (drop)
            2'd0: begin
              pair.cnt = 2'd2;
              pair.r0  = '{nibble: hi, nibble_valid: 1'b1, last: 1'b0,
                           prefix_class: cls_use, error: 1'b0};
              pair.r1  = '{nibble: lo, nibble_valid: 1'b1, last: fin,
                           prefix_class: cls_use, error: 1'b0};
            end
            2'd1: begin
              pair.cnt = 2'd1;
              pair.r0  = '{nibble: lo, nibble_valid: 1'b1, last: fin,
                           prefix_class: cls_use, error: 1'b0};
            end
            default: begin
              // whole first byte was prefix
              if (fin) begin
                pair.cnt = 2'd1;
                pair.r0  = '{nibble: 4'd0, nibble_valid: 1'b0, last: 1'b1,
                             prefix_class: cls_use, error: 1'b0};
              end
            end
          endcase
        end
      end
      default: begin
        hbl_next = ib[7:5];
        pl_next  = {{(pnu_pkg::PAYLOAD_W-5){1'b0}}, ib[4:0]};
        if (ib[7:5] != '0) begin
          phase_next = PH_EXT;
        end else begin
          first_next = 1'b1;
          cls_next   = pnu_pkg::CLS_NONE;
          if (ib[4:0] == '0) begin
            phase_next = PH_HDR;
            pair.cnt   = 2'd1;
            pair.r0    = marker;
            done       = 1'b1;
          end else begin
            phase_next = PH_PAY;
          end
        end
        if (!done && ie) begin
          phase_next = PH_HDR;
          hbl_next   = '0;
          pl_next    = '0;
          first_next = 1'b1;
          cls_next   = pnu_pkg::CLS_NONE;
          pair.cnt   = 2'd1;
          pair.r0    = err_res;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv    <= 1'b0;
      phase <= PH_HDR;
      hbl   <= '0;
      pl    <= '0;
      first <= 1'b1;
      cls   <= pnu_pkg::CLS_NONE;
    end else begin
      if (byte_stream.valid && byte_stream.ready) begin
        iv <= 1'b1;
      end else if (fire) begin
        iv <= 1'b0;
      end
      if (fire) begin
        phase <= phase_next;
        hbl   <= hbl_next;
        pl    <= pl_next;
        first <= first_next;
        cls   <= cls_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      ib <= byte_stream.in_byte;
      ie <= byte_stream.buffer_end;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pnu_serializer.sv =====
`default_nettype none

module pnu_serializer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire pnu_pkg::pair_t  pair,
  output logic                 load_ok,
  pnu_out_if.source            nibble_stream
);

  logic [1:0]       cnt;
  pnu_pkg::result_t slot0;
  pnu_pkg::result_t slot1;
  logic             pop;

  assign nibble_stream.valid        = (cnt != 2'd0);
  assign nibble_stream.nibble       = slot0.nibble;
  assign nibble_stream.nibble_valid = slot0.nibble_valid;
  assign nibble_stream.last         = slot0.last;
  assign nibble_stream.prefix_class = slot0.prefix_class;
  assign nibble_stream.error        = slot0.error;

  assign pop     = nibble_stream.valid & nibble_stream.ready;
  assign load_ok = (cnt == 2'd0) | ((cnt == 2'd1) & pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (fire) begin
      cnt <= pair.cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      slot0 <= pair.r0;
      slot1 <= pair.r1;
    end else if (pop && cnt == 2'd2) begin
      slot0 <= slot1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pnu_checker.sv =====
`default_nettype none

module pnu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] nibble,
  input wire logic       nibble_valid,
  input wire logic       last,
  input wire logic [1:0] prefix_class,
  input wire logic       error
);

  // nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word shown right after reset");

  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |->
      (last && !nibble_valid && nibble == 4'd0 && prefix_class == pnu_pkg::CLS_NONE))
    else $error("malformed error word");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !nibble_valid) |-> (last && nibble == 4'd0))
    else $error("end marker without last or with data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(nibble) && $stable(last)))
    else $error("stalled result word changed");

endmodule

bind prefixed_nibble_unpacker_unit pnu_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (nibble_stream.valid),
  .out_ready    (nibble_stream.ready),
  .nibble       (nibble_stream.nibble),
  .nibble_valid (nibble_stream.nibble_valid),
  .last         (nibble_stream.last),
  .prefix_class (nibble_stream.prefix_class),
  .error        (nibble_stream.error)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned WORDS_PER_PHASE = 400;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef enum logic [1:0] {
    PS_HEADER,
    PS_EXT,
    PS_PAYLOAD
  } parse_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pnu_in_if  byte_if ();
  pnu_out_if nib_if ();

  prefixed_nibble_unpacker_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .byte_stream   (byte_if),
    .nibble_stream (nib_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // parser copy
  logic                          strip_on;
  parse_t                        parse_st;
  logic [pnu_pkg::HDR_CNT_W-1:0] ext_left;
  logic [pnu_pkg::PAYLOAD_W-1:0] msg_left;
  logic                          first_nib;
  logic [1:0]                    held_cls;

  pnu_pkg::result_t pending_nibbles[$];
  int unsigned      fail_count = 0;
  int unsigned      bytes_sent;
  bit               idle_en;
  bit               hold_tgl = 1'b0;
  bit               hold_seen = 1'b0;
  int unsigned      rx_hold = 0;
  int unsigned      rx_stall = 0;

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_result(input logic [3:0] nib, input logic vld,
                                      input logic lst, input logic [1:0] cls,
                                      input logic err);
    pnu_pkg::result_t r;
    r.nibble       = nib;
    r.nibble_valid = vld;
    r.last         = lst;
    r.prefix_class = cls;
    r.error        = err;
    pending_nibbles.insert(pending_nibbles.size(), r);
  endfunction

  function automatic void start_payload();
    first_nib = 1'b1;
    held_cls  = pnu_pkg::CLS_NONE;
    parse_st  = (msg_left == '0) ? PS_HEADER : PS_PAYLOAD;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic e);
    logic [3:0]  hi;
    logic [3:0]  lo;
    int unsigned drop;
    logic        fin;
    logic        done;
    hi   = b[7:4];
    lo   = b[3:0];
    drop = 0;
    done = 1'b0;
    case (parse_st)
      PS_EXT: begin
        msg_left = {msg_left[pnu_pkg::PAYLOAD_W-9:0], b};
        ext_left = ext_left - {{(pnu_pkg::HDR_CNT_W-1){1'b0}}, 1'b1};
        if (ext_left == '0) begin
          start_payload();
          if (parse_st == PS_HEADER) begin
            push_result(4'h0, 1'b0, 1'b1, pnu_pkg::CLS_NONE, 1'b0);
            done = 1'b1;
          end
        end
      end
      PS_PAYLOAD: begin
        if (first_nib) begin
          first_nib = 1'b0;
          if (strip_on && hi <= pnu_pkg::NIB_MAX_PREFIX) begin
            drop     = hi[0] ? 1 : 2;
            held_cls = (hi >= pnu_pkg::NIB_ZERO_LOW) ? pnu_pkg::CLS_ZERO :
                       (hi >= pnu_pkg::NIB_PLAIN_LOW) ? pnu_pkg::CLS_PLAIN :
                       pnu_pkg::CLS_EMPTY;
          end else begin
            held_cls = pnu_pkg::CLS_NONE;
          end
        end
        msg_left = msg_left - {{(pnu_pkg::PAYLOAD_W-1){1'b0}}, 1'b1};
        fin      = (msg_left == '0);
        done     = 1'b1;
        if (e && !fin) begin
          parse_st = PS_HEADER;
          push_result(4'h0, 1'b0, 1'b1, pnu_pkg::CLS_NONE, 1'b1);
        end else begin
          if (drop == 0) push_result(hi, 1'b1, 1'b0, held_cls, 1'b0);
          if (drop < 2) push_result(lo, 1'b1, fin, held_cls, 1'b0);
          else if (fin) push_result(4'h0, 1'b0, 1'b1, held_cls, 1'b0);
          if (fin) parse_st = PS_HEADER;
        end
      end
      default: begin
        ext_left = b[7:5];
        msg_left = {{(pnu_pkg::PAYLOAD_W-5){1'b0}}, b[4:0]};
        if (ext_left != '0) begin
          parse_st = PS_EXT;
        end else begin
          start_payload();
          if (parse_st == PS_HEADER) begin
            push_result(4'h0, 1'b0, 1'b1, pnu_pkg::CLS_NONE, 1'b0);
            done = 1'b1;
          end
        end
      end
    endcase
    if (!done && e) begin
      parse_st  = PS_HEADER;
      ext_left  = '0;
      msg_left  = '0;
      first_nib = 1'b1;
      held_cls  = pnu_pkg::CLS_NONE;
      push_result(4'h0, 1'b0, 1'b1, pnu_pkg::CLS_NONE, 1'b1);
    end
  endfunction

  function automatic void field_check(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_word();
    pnu_pkg::result_t want;
    if (pending_nibbles.size() == 0) begin
      $display("%0t: unexpected word, expected none, got %0h/%0b/%0b/%0d/%0b",
               $time, nib_if.nibble, nib_if.nibble_valid, nib_if.last,
               nib_if.prefix_class, nib_if.error);
      fail_count++;
      return;
    end
    want = pending_nibbles.pop_front();
    field_check("nibble", want.nibble, nib_if.nibble);
    field_check("nibble_valid", {3'b0, want.nibble_valid}, {3'b0, nib_if.nibble_valid});
    field_check("last", {3'b0, want.last}, {3'b0, nib_if.last});
    field_check("prefix_class", {2'b0, want.prefix_class}, {2'b0, nib_if.prefix_class});
    field_check("error", {3'b0, want.error}, {3'b0, nib_if.error});
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      nib_if.ready <= 1'b0;
    end else begin
      if (nib_if.valid && nib_if.ready) check_word();
      if (hold_tgl != hold_seen) begin
        hold_seen = hold_tgl;
        rx_hold   = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        nib_if.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        nib_if.ready <= 1'b0;
      end else begin
        rx_stall = idle_gap();
        if (rx_stall > 0) begin
          rx_stall--;
          nib_if.ready <= 1'b0;
        end else begin
          nib_if.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    int unsigned gap;
    byte_if.valid      <= 1'b1;
    byte_if.in_byte    <= b;
    byte_if.buffer_end <= e;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    parse_byte(b, e);
    bytes_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_nibbles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == pnu_pkg::ADDR_STRIP) strip_on = data[0];
  endtask

  // cut < 0 sends the whole message
  task automatic send_message(input int unsigned len, input int unsigned n_ext,
                              input int cut);
    logic [7:0]  msg[$];
    int unsigned i;
    int unsigned stop;
    logic        end_flag;
    if (n_ext == 0) begin
      msg.insert(msg.size(), {3'd0, 5'(len)});
    end else begin
      msg.insert(msg.size(), {3'(n_ext), 5'd0});
      for (i = 1; i < n_ext; i++) msg.insert(msg.size(), 8'h00);
      msg.insert(msg.size(), 8'(len));
    end
    for (i = 0; i < len; i++) begin
      if (i == 0 && $urandom_range(0, 1) == 1)
        msg.insert(msg.size(), {4'($urandom_range(0, 5)), 4'($urandom)});
      else
        msg.insert(msg.size(), 8'($urandom));
    end
    stop     = (cut >= 0) ? cut : msg.size() - 1;
    end_flag = (cut >= 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
    for (i = 0; i <= stop; i++) send_byte(msg[i], (i == stop) ? end_flag : 1'b0);
  endtask

  task automatic send_noise();
    int unsigned k;
    int unsigned i;
    k = $urandom_range(1, 10);
    if ($urandom_range(0, 1) == 1) send_byte({3'd7, 5'($urandom)}, 1'b0);
    for (i = 0; i < k; i++) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
    send_byte(8'($urandom), 1'b1);
  endtask

  task automatic random_sequence();
    int unsigned r;
    int unsigned len;
    int unsigned n_ext;
    int unsigned total;
    r = $urandom_range(0, 99);
    len = $urandom_range(0, 99);
    if (len < 70) len = $urandom_range(0, 4);
    else if (len < 95) len = $urandom_range(5, 16);
    else len = $urandom_range(17, 40);
    n_ext = (len > 31 || $urandom_range(0, 9) < 3) ? $urandom_range(1, 7) : 0;
    total = 1 + n_ext + len;
    if (r < 70 || (r < 85 && total < 2)) send_message(len, n_ext, -1);
    else if (r < 85) send_message(len, n_ext, $urandom_range(0, total - 2));
    else send_noise();
  endtask

  task automatic test_prefix_classes();
    send_byte(8'h02, 1'b0); send_byte(8'h0A, 1'b0); send_byte(8'hBC, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h1D, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h25, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h37, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h48, 1'b0);
    send_byte(8'h02, 1'b0); send_byte(8'h59, 1'b0); send_byte(8'hA1, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'hF0, 1'b0);
  endtask

  task automatic test_special_cases();
    // empty payload, short and extended header
    send_byte(8'h00, 1'b0);
    send_byte(8'h20, 1'b0); send_byte(8'h00, 1'b0);
    // buffer ends inside payload, then inside header
    send_byte(8'h03, 1'b0); send_byte(8'h12, 1'b1);
    send_byte(8'h21, 1'b1);
    // buffer end on a byte that completes the message
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0); send_byte(8'h6C, 1'b1);
  endtask

  task automatic test_strip_register();
    settle();
    apb_write(pnu_pkg::ADDR_STRIP, 32'd0);
    send_byte(8'h01, 1'b0); send_byte(8'h12, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h48, 1'b0);
    // register changes while a message is open
    send_byte(8'h02, 1'b0);
    settle();
    apb_write(pnu_pkg::ADDR_STRIP, 32'd1);
    send_byte(8'h1A, 1'b0); send_byte(8'hBC, 1'b0);
    send_byte(8'h02, 1'b0); send_byte(8'h3A, 1'b0);
    settle();
    apb_write(pnu_pkg::ADDR_STRIP, 32'd0);
    send_byte(8'hBC, 1'b0);
    settle();
    apb_write(pnu_pkg::ADDR_STRIP, 32'd1);
  endtask

  task automatic test_backpressure();
    int unsigned i;
    settle();
    idle_en  = 1'b0;
    hold_tgl = ~hold_tgl;
    for (i = 0; i < 25; i++) send_message($urandom_range(2, 6), 0, -1);
    settle();
    idle_en = 1'b1;
  endtask

  task automatic test_random();
    int unsigned ph;
    int unsigned start;
    for (ph = 0; ph < 4; ph++) begin
      settle();
      apb_write(pnu_pkg::ADDR_STRIP, (ph % 2 == 0) ? 32'd0 : 32'd1);
      idle_en = (ph != 2);
      start = bytes_sent;
      while (bytes_sent - start < WORDS_PER_PHASE) random_sequence();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    byte_if.valid      = 1'b0;
    byte_if.in_byte    = '0;
    byte_if.buffer_end = 1'b0;
    bytes_sent         = 0;
    idle_en            = 1'b1;
    strip_on           = 1'b1;
    parse_st           = PS_HEADER;
    ext_left           = '0;
    msg_left           = '0;
    first_nib          = 1'b1;
    held_cls           = pnu_pkg::CLS_NONE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_prefix_classes();
    test_special_cases();
    test_strip_register();
    test_backpressure();
    test_random();

    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== prefixed_nibble_unpacker_unit.f =====
rtl/core/pnu_pkg.sv
rtl/core/pnu_in_if.sv
rtl/core/pnu_out_if.sv
rtl/core/pnu_cfg_regs.sv
rtl/core/pnu_parser.sv
rtl/core/pnu_serializer.sv
rtl/core/prefixed_nibble_unpacker_unit.sv
rtl/core/pnu_checker.sv
tb/tb_top.sv
